/* design/imuoc_pkg.sv */
// ----------------------------------------------------------------------------
// imuoc_pkg: shared constants and helpers for the IMU offset calibrator
// Holds the sample count used for averaging, the datapath widths and the
// reciprocal constants used to divide an axis sum by the sample count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imuoc_pkg;

  // Number of samples averaged after reset (range 1 to 256).
  localparam int CAL_SAMPLES = 200;

  localparam int AXES   = 6;
  localparam int WORD_W = 16;
  localparam int SUM_W  = 24;
  localparam int CNT_W  = 8;
  localparam int EXT_W  = WORD_W + 2;

  // Exact truncating division of a magnitude below 2**SUM_W by CAL_SAMPLES:
  // q = (mag * DIV_MUL) >> DIV_SH, with DIV_MUL = ceil(2**DIV_SH / CAL_SAMPLES).
  localparam int DIV_SH    = SUM_W + $clog2(CAL_SAMPLES);
  localparam int MUL_W     = SUM_W + 1;
  localparam int PROD_W    = SUM_W + MUL_W;
  localparam int QUO_W     = WORD_W + 1;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'((((64'd1) << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(CAL_SAMPLES - 1);

  localparam logic signed [WORD_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN = -16'sh8000;

  // Lane control for one accepted sample.
  typedef struct packed {
    logic acc;    // add this sample's corrected word into the axis sum
    logic load;   // this sample completes calibration: load the offset
  } lane_ctl_t;

  // Saturate a wide signed value to a signed 16-bit word.
  function automatic logic signed [WORD_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > EXT_W'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < EXT_W'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/imuoc_lane.sv */
// ----------------------------------------------------------------------------
// imuoc_lane: one axis of the offset calibrator
// Subtracts the stored offset with saturation, accumulates the corrected
// word during calibration and loads the average as the new offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imuoc_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire imuoc_pkg::lane_ctl_t                ctl,
  input  wire logic signed [imuoc_pkg::WORD_W-1:0] raw,
  output logic signed [imuoc_pkg::WORD_W-1:0]      corr
);

  logic signed [imuoc_pkg::WORD_W-1:0] offset_r, offset_nxt;
  logic signed [imuoc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [imuoc_pkg::EXT_W-1:0]  diff;
  logic                                neg;
  logic [imuoc_pkg::SUM_W-1:0]         mag;
  logic [imuoc_pkg::PROD_W-1:0]        prod;
  logic [imuoc_pkg::QUO_W-1:0]         quo;
  logic signed [imuoc_pkg::EXT_W-1:0]  avg;

  always_comb begin
    diff = imuoc_pkg::EXT_W'(raw) - imuoc_pkg::EXT_W'(offset_r);
    corr = imuoc_pkg::sat16(diff);
    sum_nxt = ctl.acc ? sum_r + imuoc_pkg::SUM_W'(corr) : sum_r;

    // Truncation toward zero: divide the magnitude, then restore the sign.
    neg  = sum_nxt[imuoc_pkg::SUM_W-1];
    mag  = neg ? imuoc_pkg::SUM_W'(-sum_nxt) : imuoc_pkg::SUM_W'(sum_nxt);
    prod = imuoc_pkg::PROD_W'(mag) * imuoc_pkg::PROD_W'(imuoc_pkg::DIV_MUL);
    quo  = prod[imuoc_pkg::DIV_SH +: imuoc_pkg::QUO_W];
    avg  = neg ? -imuoc_pkg::EXT_W'(quo) : imuoc_pkg::EXT_W'(quo);
    offset_nxt = ctl.load ? imuoc_pkg::sat16(avg) : offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      sum_r    <= '0;
    end else begin
      offset_r <= offset_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/imu_offset_calibrate.sv */
// ----------------------------------------------------------------------------
// imu_offset_calibrate: zero-bias calibration of a six-axis IMU by averaging
//
// Usage:
//   in_*  channel carries one six-axis sample per beat. in_tdata holds the
//         three accelerometer words then the three gyroscope words, each a
//         signed 16-bit value.
//   out_* channel returns one beat per input beat: the six offset-corrected
//         words, saturated to signed 16 bits, in out_tdata, and the
//         calibrated flag in out_tuser.
//   After reset the offsets are zero and the first CAL_SAMPLES samples are
//   summed per axis. The sample that completes that count still leaves with
//   zero offsets but with the calibrated flag set; its sums divided by
//   CAL_SAMPLES (truncated toward zero) become the offsets applied from the
//   next sample on, until the next reset.
//   A beat passes the input, then the result register. One beat is accepted
//   every cycle unless stalled; the per-beat path is one subtract and saturate
//   per axis, the sum update and a constant-reciprocal multiply for the average.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_tready drops only when both are occupied.
//   Reset is synchronous and clears the offsets, sums, count, flag and the
//   valid bits of both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_offset_calibrate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: accel_x_raw, accel_y_raw, accel_z_raw,
  //           gyro_x_raw, gyro_y_raw, gyro_z_raw (16 bits each, lowest first)
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,
  // out_tdata: accel_x_out, accel_y_out, accel_z_out,
  //            gyro_x_out, gyro_y_out, gyro_z_out (16 bits each, lowest first)
  // out_tuser: calibrated
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,
  output logic             out_tuser
);

  localparam int W = imuoc_pkg::WORD_W;

  // Input register stage.
  logic        in_vld_r, in_vld_nxt;
  logic [95:0] in_data_r, in_data_nxt;

  // Result register stage.
  logic        out_vld_r, out_vld_nxt;
  logic [95:0] out_data_r, out_data_nxt;
  logic        out_cal_r, out_cal_nxt;

  // Calibration control.
  logic [imuoc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                        done_r, done_nxt;

  logic                 adv;     // input register beat moves to result register
  logic                 finish;  // this beat completes calibration
  imuoc_pkg::lane_ctl_t ctl;
  logic [95:0]          corr_data;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign finish    = adv && !done_r && (count_r == imuoc_pkg::LAST_COUNT);

  always_comb begin
    ctl.acc  = adv && !done_r;
    ctl.load = finish;
  end

  // One lane per axis; each owns its offset and running sum.
  for (genvar a = 0; a < imuoc_pkg::AXES; a++) begin : g_lane
    logic signed [W-1:0] lane_corr;
    imuoc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .raw   (in_data_r[a*W +: W]),
      .corr  (lane_corr)
    );
    assign corr_data[a*W +: W] = lane_corr;
  end

  always_comb begin
    in_vld_nxt   = in_vld_r;
    in_data_nxt  = in_data_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_cal_nxt  = out_cal_r;
    count_nxt    = count_r;
    done_nxt     = done_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (adv) begin
      in_vld_nxt   = 1'b0;
      out_vld_nxt  = 1'b1;
      out_data_nxt = corr_data;
      out_cal_nxt  = done_r || finish;
    end
    if (in_tvalid && in_tready) begin
      in_vld_nxt  = 1'b1;
      in_data_nxt = in_tdata;
    end
    // The count stops at its last value once calibration is done.
    if (ctl.acc && !finish) begin
      count_nxt = count_r + 1'b1;
    end
    if (finish) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
      done_r    <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      count_r   <= count_nxt;
      done_r    <= done_nxt;
    end
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
    out_cal_r  <= out_cal_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cal_r;

  // Once calibrated, the block stays calibrated until reset.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("calibrated flag dropped without reset");

  // While pending, the count stays below the number of samples to average.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (count_r <= imuoc_pkg::LAST_COUNT))
    else $error("sample count ran past the averaging length");

  // The beat that completes the count sets the flag.
  a_finish_sets: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> done_r)
    else $error("calibration completed but flag not set");

  // Every beat that leaves carries the flag as it stands after its update.
  a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_tvalid && (out_tuser == done_r)))
    else $error("result beat flag disagrees with calibration state");

endmodule

`default_nettype wire
